// ===== rtl/ppc_pkg.sv =====
package ppc_pkg;

    // fixed widths of the payload
    localparam int COORD_BITS   = 24;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int MUL_BITS     = DIFF_BITS + 1;
    localparam int PROD_BITS    = 2 * MUL_BITS;
    localparam int ACC_BITS     = 2 * DIFF_BITS;
    localparam int SQ_BITS      = 36;
    localparam int ID_BITS      = 16;
    localparam int QUO_BITS     = SQ_BITS + 1;
    localparam int WIDE_BITS    = 2 * ACC_BITS;
    localparam int CFG_IDX_BITS = 2;
    localparam int CNT_BITS     = $clog2(QUO_BITS);

    localparam logic [SQ_BITS-1:0] CAP_SQ     = 36'd65536000000;
    localparam logic [SQ_BITS-1:0] NEAR_RESET = 36'd16384;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_X    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_Y    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_LIMIT = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic [ID_BITS-1:0]           lane_id;
        logic                         path_end;
    } in_word_t;

    typedef struct packed {
        logic [ID_BITS-1:0] hit_lane_id;
        logic               is_near;
        logic [SQ_BITS-1:0] min_dist_sq;
    } out_word_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LEN_A,
        OP_LEN_B,
        OP_DOT_A,
        OP_DOT_B,
        OP_CR_A,
        OP_CR_B,
        OP_SQ_0,
        OP_SQ_1,
        OP_SQ_2,
        OP_SQ_3,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_ST_A,
        OP_ST_B,
        OP_ST_DONE,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LEN_A,
        S_LEN_B,
        S_DOT_A,
        S_DOT_B,
        S_CLASS,
        S_CR_A,
        S_CR_B,
        S_SQ_0,
        S_SQ_1,
        S_SQ_2,
        S_SQ_3,
        S_DIV_INIT,
        S_DIV,
        S_DIV_DONE,
        S_ST_A,
        S_ST_B,
        S_ST_DONE,
        S_FINISH
    } ppc_state_t;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic have_prev;
        logic zero_len;
        logic dot_perp;
        logic dot_start;
        logic path_end;
        logic out_full;
    } dp_status_t;

endpackage

// ===== rtl/ppc_ctrl.sv =====
module ppc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    input  ppc_pkg::dp_status_t status,
    output ppc_pkg::dp_cmd_t    cmd
);
    import ppc_pkg::*;

    ppc_state_t          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                finish_stall;

    assign finish_stall = status.path_end && status.out_full && !out_ready;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_LEN_A;
            S_LEN_A:
            begin
                if (!status.have_prev || status.zero_len)
                    state_next = S_FINISH;
                else
                    state_next = S_LEN_B;
            end
            S_LEN_B:    state_next = S_DOT_A;
            S_DOT_A:    state_next = S_DOT_B;
            S_DOT_B:    state_next = S_CLASS;
            S_CLASS:
            begin
                if (status.dot_perp)
                    state_next = S_CR_A;
                else if (status.dot_start)
                    state_next = S_ST_A;
                else
                    state_next = S_FINISH;
            end
            S_CR_A:     state_next = S_CR_B;
            S_CR_B:     state_next = S_SQ_0;
            S_SQ_0:     state_next = S_SQ_1;
            S_SQ_1:     state_next = S_SQ_2;
            S_SQ_2:     state_next = S_SQ_3;
            S_SQ_3:     state_next = S_DIV_INIT;
            S_DIV_INIT:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(QUO_BITS - 1))
                    state_next = S_DIV_DONE;
            end
            S_DIV_DONE: state_next = S_FINISH;
            S_ST_A:     state_next = S_ST_B;
            S_ST_B:     state_next = S_ST_DONE;
            S_ST_DONE:  state_next = S_FINISH;
            S_FINISH:   if (!finish_stall) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.op      = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_LEN_A:    cmd.op = OP_LEN_A;
            S_LEN_B:    cmd.op = OP_LEN_B;
            S_DOT_A:    cmd.op = OP_DOT_A;
            S_DOT_B:    cmd.op = OP_DOT_B;
            S_CR_A:     cmd.op = OP_CR_A;
            S_CR_B:     cmd.op = OP_CR_B;
            S_SQ_0:     cmd.op = OP_SQ_0;
            S_SQ_1:     cmd.op = OP_SQ_1;
            S_SQ_2:     cmd.op = OP_SQ_2;
            S_SQ_3:     cmd.op = OP_SQ_3;
            S_DIV_INIT: cmd.op = OP_DIV_INIT;
            S_DIV:      cmd.op = OP_DIV_STEP;
            S_DIV_DONE: cmd.op = OP_DIV_DONE;
            S_ST_A:     cmd.op = OP_ST_A;
            S_ST_B:     cmd.op = OP_ST_B;
            S_ST_DONE:  cmd.op = OP_ST_DONE;
            S_FINISH:   if (!finish_stall) cmd.op = OP_FINISH;
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/ppc_datapath.sv =====
module ppc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ppc_pkg::in_word_t             in_word,
    input  logic                          out_ready,
    output logic                          out_valid,
    output ppc_pkg::out_word_t            out_word,
    input  logic                          cfg_we,
    input  logic [ppc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ppc_pkg::SQ_BITS-1:0]   cfg_data,
    input  ppc_pkg::dp_cmd_t              cmd,
    output ppc_pkg::dp_status_t           status
);
    import ppc_pkg::*;

    // configuration
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic [SQ_BITS-1:0]           limit_reg;

    // item and segment state
    logic signed [COORD_BITS-1:0] px_reg, py_reg, vx_reg, vy_reg;
    logic                         have_prev_reg;
    logic [ID_BITS-1:0]           id_reg;
    logic                         pend_reg;
    logic [SQ_BITS-1:0]           best_reg, best_next;
    logic signed [DIFF_BITS-1:0]  dx_reg, dy_reg, ex_reg, ey_reg;
    logic [ACC_BITS-1:0]          len_reg, st_reg;
    logic signed [ACC_BITS:0]     dot_reg, cross_reg;
    logic [WIDE_BITS-1:0]         sq_reg;
    logic [ACC_BITS:0]            rem_reg;
    logic [QUO_BITS-1:0]          qsh_reg;
    logic                         ovf_reg;
    logic                         out_valid_reg, out_valid_next;
    out_word_t                    out_reg;

    // shared multiplier
    logic signed [MUL_BITS-1:0]   mul_a, mul_b;
    logic signed [PROD_BITS-1:0]  prod;
    logic [ACC_BITS-1:0]          prod_u;
    logic [ACC_BITS:0]            cabs;
    logic [DIFF_BITS-1:0]         c_lo, c_hi;
    logic [ACC_BITS:0]            trial;
    logic                         trial_ge;
    logic [SQ_BITS-1:0]           cand;
    logic                         cand_en;

    assign cabs = cross_reg[ACC_BITS] ? (ACC_BITS+1)'(0) - cross_reg : cross_reg;
    assign c_lo = cabs[DIFF_BITS-1:0];
    assign c_hi = cabs[ACC_BITS-1:DIFF_BITS];

    // operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_LEN_A: begin mul_a = MUL_BITS'(dx_reg); mul_b = MUL_BITS'(dx_reg); end
            OP_LEN_B: begin mul_a = MUL_BITS'(dy_reg); mul_b = MUL_BITS'(dy_reg); end
            OP_DOT_A: begin mul_a = MUL_BITS'(ex_reg); mul_b = MUL_BITS'(dx_reg); end
            OP_DOT_B: begin mul_a = MUL_BITS'(ey_reg); mul_b = MUL_BITS'(dy_reg); end
            OP_CR_A:  begin mul_a = MUL_BITS'(ex_reg); mul_b = MUL_BITS'(dy_reg); end
            OP_CR_B:  begin mul_a = MUL_BITS'(ey_reg); mul_b = MUL_BITS'(dx_reg); end
            OP_ST_A:  begin mul_a = MUL_BITS'(ex_reg); mul_b = MUL_BITS'(ex_reg); end
            OP_ST_B:  begin mul_a = MUL_BITS'(ey_reg); mul_b = MUL_BITS'(ey_reg); end
            OP_SQ_0:  begin mul_a = {1'b0, c_lo}; mul_b = {1'b0, c_lo}; end
            OP_SQ_1:  begin mul_a = {1'b0, c_lo}; mul_b = {1'b0, c_hi}; end
            OP_SQ_2:  begin mul_a = {1'b0, c_hi}; mul_b = {1'b0, c_lo}; end
            OP_SQ_3:  begin mul_a = {1'b0, c_hi}; mul_b = {1'b0, c_hi}; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod_u = prod[ACC_BITS-1:0];

    // one restoring division step
    assign trial    = {rem_reg[ACC_BITS-1:0], qsh_reg[QUO_BITS-1]};
    assign trial_ge = trial >= {1'b0, len_reg};

    // candidate distance of this segment
    always_comb
    begin
        cand    = CAP_SQ;
        cand_en = 1'b0;
        case (cmd.op)
            OP_DIV_DONE:
            begin
                cand_en = 1'b1;
                if (!ovf_reg && qsh_reg < {1'b0, CAP_SQ})
                    cand = qsh_reg[SQ_BITS-1:0];
            end
            OP_ST_DONE:
            begin
                cand_en = 1'b1;
                if (st_reg < ACC_BITS'(CAP_SQ))
                    cand = st_reg[SQ_BITS-1:0];
            end
            default:
            begin
                cand    = CAP_SQ;
                cand_en = 1'b0;
            end
        endcase
        best_next = (cand_en && cand < best_reg) ? cand : best_reg;
    end

    // result word handshake
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.op == OP_FINISH && pend_reg)
            out_valid_next = 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg        <= '0;
            qy_reg        <= '0;
            limit_reg     <= NEAR_RESET;
            px_reg        <= '0;
            py_reg        <= '0;
            have_prev_reg <= 1'b0;
            best_reg      <= CAP_SQ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_QUERY_X:    qx_reg    <= cfg_data[COORD_BITS-1:0];
                    CFG_QUERY_Y:    qy_reg    <= cfg_data[COORD_BITS-1:0];
                    CFG_NEAR_LIMIT: limit_reg <= cfg_data;
                    default:        ;
                endcase
            end
            out_valid_reg <= out_valid_next;
            if (cmd.op == OP_FINISH)
            begin
                if (pend_reg)
                begin
                    best_reg      <= CAP_SQ;
                    have_prev_reg <= 1'b0;
                    px_reg        <= '0;
                    py_reg        <= '0;
                end
                else
                begin
                    have_prev_reg <= 1'b1;
                    px_reg        <= vx_reg;
                    py_reg        <= vy_reg;
                end
            end
            else
            begin
                best_reg <= best_next;
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            vx_reg   <= in_word.vertex_x;
            vy_reg   <= in_word.vertex_y;
            id_reg   <= in_word.lane_id;
            pend_reg <= in_word.path_end;
            dx_reg   <= DIFF_BITS'(in_word.vertex_x) - DIFF_BITS'(px_reg);
            dy_reg   <= DIFF_BITS'(in_word.vertex_y) - DIFF_BITS'(py_reg);
            ex_reg   <= DIFF_BITS'(qx_reg) - DIFF_BITS'(px_reg);
            ey_reg   <= DIFF_BITS'(qy_reg) - DIFF_BITS'(py_reg);
        end
        case (cmd.op)
            OP_LEN_A: len_reg   <= prod_u;
            OP_LEN_B: len_reg   <= len_reg + prod_u;
            OP_DOT_A: dot_reg   <= prod[ACC_BITS:0];
            OP_DOT_B: dot_reg   <= dot_reg + prod[ACC_BITS:0];
            OP_CR_A:  cross_reg <= prod[ACC_BITS:0];
            OP_CR_B:  cross_reg <= cross_reg - prod[ACC_BITS:0];
            OP_ST_A:  st_reg    <= prod_u;
            OP_ST_B:  st_reg    <= st_reg + prod_u;
            OP_SQ_0:  sq_reg    <= WIDE_BITS'(prod_u);
            OP_SQ_1,
            OP_SQ_2:  sq_reg    <= sq_reg + {(ACC_BITS-DIFF_BITS)'(0), prod_u,
                                             DIFF_BITS'(0)};
            OP_SQ_3:  sq_reg    <= sq_reg + {prod_u, ACC_BITS'(0)};
            OP_DIV_INIT:
            begin
                ovf_reg <= sq_reg[WIDE_BITS-1:QUO_BITS] >=
                           (WIDE_BITS-QUO_BITS)'(len_reg);
                rem_reg <= {1'b0, sq_reg[QUO_BITS+ACC_BITS-1:QUO_BITS]};
                qsh_reg <= sq_reg[QUO_BITS-1:0];
            end
            OP_DIV_STEP:
            begin
                rem_reg <= trial_ge ? trial - {1'b0, len_reg} : trial;
                qsh_reg <= {qsh_reg[QUO_BITS-2:0], trial_ge};
            end
            OP_FINISH:
            begin
                if (pend_reg)
                begin
                    out_reg.hit_lane_id <= id_reg;
                    out_reg.is_near     <= best_reg < limit_reg;
                    out_reg.min_dist_sq <= best_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // status to the controller
    assign status.have_prev = have_prev_reg;
    assign status.zero_len  = (dx_reg == '0) && (dy_reg == '0);
    assign status.dot_perp  = !dot_reg[ACC_BITS] && (dot_reg != '0) &&
                              (dot_reg[ACC_BITS-1:0] < len_reg);
    assign status.dot_start = dot_reg[ACC_BITS] || (dot_reg == '0);
    assign status.path_end  = pend_reg;
    assign status.out_full  = out_valid_reg;

endmodule

// ===== rtl/polyline_proximity_classifier.sv =====
// polyline proximity classifier
// input channel in_valid/in_ready carries one vertex word: x, y (signed,
// 1/256 m), lane id and a path end flag. output channel out_valid/out_ready
// carries one word per finished path: lane id, near flag and the minimum
// squared distance (1/65536 m^2, capped at 1000 m squared).
// query point and threshold are written through cfg_we/cfg_index/cfg_data,
// index 0 query x, 1 query y, 2 threshold; the user must write them only
// while the block is idle, which the block does not enforce. one vertex is
// worked on at a time; in_ready is high only when idle. the perpendicular
// distance runs a 37-step restoring divider, and one 26x26 multiplier is
// shared by all products. results sit in an output register; the next
// vertex is accepted while a result waits, and only a second path end
// stalls until the word is taken. reset clears the query point to 0, the
// threshold to 0.5 m, the running minimum to the cap and drops any held
// result.
module polyline_proximity_classifier (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  ppc_pkg::in_word_t                in_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output ppc_pkg::out_word_t               out_word,
    input  logic                             cfg_we,
    input  logic [ppc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ppc_pkg::SQ_BITS-1:0]      cfg_data
);
    import ppc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    ppc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and state
    ppc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== rtl/ppc_checker.sv =====
module ppc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input ppc_pkg::in_word_t                in_word,
    input logic                             out_valid,
    input logic                             out_ready,
    input ppc_pkg::out_word_t               out_word
);
    import ppc_pkg::*;

    // a held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // reported minimum never exceeds the cap
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.min_dist_sq <= CAP_SQ)
        else $error("minimum above cap");

    // one vertex at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a vertex while busy");

    // a vertex without path end, accepted while no word is held, raises no new word
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_word.path_end && !out_valid |=> ##1 !out_valid)
        else $error("result without path end");

endmodule

bind polyline_proximity_classifier ppc_checker u_ppc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

// ===== bench/tb_top.sv =====
module tb_top;
    import ppc_pkg::*;

    localparam int DRAIN_CYCLES = 64;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [ID_BITS-1:0]           id;
        bit                           last;
        bit                           typed;
        bit                           near;
        logic [SQ_BITS-1:0]           min_sq;
    } vec_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_word_t in_word;
    logic out_valid;
    logic out_ready;
    out_word_t out_word;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [SQ_BITS-1:0] cfg_data;

    // mirror of the block's state and registers
    logic signed [COORD_BITS-1:0] q_x, q_y;
    logic [SQ_BITS-1:0] near_lim;
    logic signed [COORD_BITS-1:0] last_x, last_y;
    bit last_valid;
    logic [SQ_BITS-1:0] lane_min;

    out_word_t pending_hits[$];
    int errors;
    int words_in;
    int hits_seen;
    bit idling;
    vec_row_t rows[12];

    polyline_proximity_classifier dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // candidate distance of one segment against the running minimum
    function automatic void fold_segment(logic signed [COORD_BITS-1:0] x2,
                                         logic signed [COORD_BITS-1:0] y2);
        logic signed [127:0] dx, dy, ex, ey, len2, dot, crs, sq, lim, cand;
        logic [SQ_BITS-1:0] c;
        dx = x2 - last_x;
        dy = y2 - last_y;
        ex = q_x - last_x;
        ey = q_y - last_y;
        if (dx == 0 && dy == 0)
            return;
        len2 = dx * dx + dy * dy;
        dot = ex * dx + ey * dy;
        if (dot > 0 && dot < len2)
        begin
            crs = ex * dy - ey * dx;
            if (crs < 0)
                crs = -crs;
            sq = crs * crs;
            lim = $signed({92'd0, CAP_SQ}) * len2;
            if (sq < lim)
            begin
                cand = sq / len2;
                c = cand[SQ_BITS-1:0];
            end
            else
                c = CAP_SQ;
        end
        else if (dot <= 0)
        begin
            cand = ex * ex + ey * ey;
            c = (cand < $signed({92'd0, CAP_SQ})) ? cand[SQ_BITS-1:0] : CAP_SQ;
        end
        else
            return;
        if (c < lane_min)
            lane_min = c;
    endfunction

    // advance the mirror by one vertex; returns 1 when a path closes
    function automatic bit track_vertex(in_word_t w, output out_word_t hit);
        hit = '0;
        if (last_valid)
            fold_segment(w.vertex_x, w.vertex_y);
        if (w.path_end)
        begin
            hit.hit_lane_id = w.lane_id;
            hit.is_near = lane_min < near_lim;
            hit.min_dist_sq = lane_min;
            lane_min = CAP_SQ;
            last_valid = 0;
            last_x = '0;
            last_y = '0;
            return 1;
        end
        last_x = w.vertex_x;
        last_y = w.vertex_y;
        last_valid = 1;
        return 0;
    endfunction

    task automatic send_vertex(in_word_t w, bit typed, bit near, logic [SQ_BITS-1:0] exp_sq);
        out_word_t hit;
        @(negedge clk);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (!in_ready);
        words_in++;
        if (track_vertex(w, hit))
        begin
            if (typed)
            begin
                hit.is_near = near;
                hit.min_dist_sq = exp_sq;
            end
            pending_hits = {pending_hits, hit};
        end
    endtask

    // drain, let the block settle, then write one register
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SQ_BITS-1:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_hits.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_QUERY_X:    q_x = val[COORD_BITS-1:0];
            CFG_QUERY_Y:    q_y = val[COORD_BITS-1:0];
            CFG_NEAR_LIMIT: near_lim = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_coord(logic signed [COORD_BITS-1:0] ctr);
        if ($urandom_range(0, 4) == 0)
            return COORD_BITS'($urandom);
        return COORD_BITS'(ctr + $signed(COORD_BITS'($urandom_range(0, 4096))) - 2048);
    endfunction

    task automatic random_paths(int count);
        in_word_t w;
        int n;
        while (count > 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                // noise word
                w = {$urandom, $urandom, 1'($urandom)};
                send_vertex(w, 0, 0, '0);
                count--;
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                begin
                    w.vertex_x = pick_coord(q_x);
                    w.vertex_y = pick_coord(q_y);
                    w.lane_id = ID_BITS'($urandom);
                    w.path_end = (k == n - 1);
                    send_vertex(w, 0, 0, '0);
                end
                count -= n;
            end
            if (count < 100 && words_in > 650)
                idling = 0;
        end
    endtask

    // compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("unexpected result word, lane %0h", out_word.hit_lane_id);
                errors++;
            end
            else
            begin
                out_word_t exp_hit;
                exp_hit = pending_hits.pop_front();
                hits_seen++;
                if (out_word.hit_lane_id !== exp_hit.hit_lane_id)
                begin
                    $error("hit_lane_id exp %0h got %0h", exp_hit.hit_lane_id,
                           out_word.hit_lane_id);
                    errors++;
                end
                if (out_word.is_near !== exp_hit.is_near)
                begin
                    $error("is_near exp %0b got %0b", exp_hit.is_near, out_word.is_near);
                    errors++;
                end
                if (out_word.min_dist_sq !== exp_hit.min_dist_sq)
                begin
                    $error("min_dist_sq exp %0d got %0d", exp_hit.min_dist_sq,
                           out_word.min_dist_sq);
                    errors++;
                end
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idling && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        in_word_t w;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        words_in = 0;
        hits_seen = 0;
        idling = 1;
        q_x = '0;
        q_y = '0;
        near_lim = NEAR_RESET;
        last_x = '0;
        last_y = '0;
        last_valid = 0;
        lane_min = CAP_SQ;

        // directed vectors against the reset configuration
        rows[0]  = '{5, 5, 16'h1234, 1, 1, 0, CAP_SQ};
        rows[1]  = '{24'sh7fffff, -24'sh800000, 16'h0000, 0, 0, 0, '0};
        rows[2]  = '{-24'sh800000, 24'sh7fffff, 16'hffff, 1, 0, 0, '0};
        rows[3]  = '{3, 4, 16'h0007, 0, 0, 0, '0};
        rows[4]  = '{100, 100, 16'h0007, 1, 1, 1, 36'd25};
        rows[5]  = '{10, 0, 16'h0008, 0, 0, 0, '0};
        rows[6]  = '{10, 0, 16'h0008, 1, 1, 0, CAP_SQ};
        rows[7]  = '{-256, 256, 16'h0009, 0, 0, 0, '0};
        rows[8]  = '{256, 256, 16'h0009, 1, 1, 0, 36'd65536};
        rows[9]  = '{-512, 0, 16'h000a, 0, 0, 0, '0};
        rows[10] = '{-256, 0, 16'h000a, 1, 1, 0, CAP_SQ};
        rows[11] = '{256, 0, 16'h000b, 1, 1, 0, CAP_SQ};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            w.vertex_x = rows[i].x;
            w.vertex_y = rows[i].y;
            w.lane_id = rows[i].id;
            w.path_end = rows[i].last;
            send_vertex(w, rows[i].typed, rows[i].near, rows[i].min_sq);
        end
        // foot exactly on the start vertex
        send_vertex('{0, 0, 16'h000c, 0}, 0, 0, '0);
        send_vertex('{256, 0, 16'h000c, 1}, 1, 1, '0);
        random_paths(180);

        // extreme query, threshold just above the cap
        write_reg(CFG_QUERY_X, 36'h0007fffff);
        write_reg(CFG_QUERY_Y, 36'hfff800000);
        write_reg(CFG_NEAR_LIMIT, CAP_SQ + 1);
        send_vertex('{-7, 9, 16'h0100, 1}, 1, 1, CAP_SQ);
        random_paths(180);

        // zero threshold, opposite corner, ignored register index
        write_reg(CFG_QUERY_X, 36'hab7800000);
        write_reg(CFG_QUERY_Y, 36'h5407fffff);
        write_reg(CFG_NEAR_LIMIT, '0);
        write_reg(CFG_UNUSED, 36'hfffffffff);
        random_paths(180);

        // random query, full-scale threshold
        write_reg(CFG_QUERY_X, SQ_BITS'({$urandom, $urandom}));
        write_reg(CFG_QUERY_Y, SQ_BITS'({$urandom, $urandom}));
        write_reg(CFG_NEAR_LIMIT, 36'hfffffffff);
        random_paths(90);
        write_reg(CFG_NEAR_LIMIT, SQ_BITS'({$urandom, $urandom} % (CAP_SQ + 1)));
        random_paths(100);

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_hits.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d vertex words, checked %0d path results", words_in, hits_seen);
        $display("covered reset, extreme and random query/threshold settings");
        if (errors == 0 && pending_hits.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
